[rtl/b64e_pkg.sv]
`default_nettype none
package b64e_pkg;

  // Depth of the group queue between the byte collector and the character emitter.
  localparam int unsigned QueueDepthDef = 2;

  localparam logic [7:0] PadChar = 8'h3D;

  // Number of bytes in a group, 1 to 3.
  localparam logic [1:0] LenOne   = 2'd1;
  localparam logic [1:0] LenTwo   = 2'd2;
  localparam logic [1:0] LenThree = 2'd3;

  // Position of a character inside its four-character group.
  localparam logic [1:0] PosFirst  = 2'd0;
  localparam logic [1:0] PosSecond = 2'd1;
  localparam logic [1:0] PosThird  = 2'd2;
  localparam logic [1:0] PosFourth = 2'd3;

  typedef struct packed {
    logic [23:0] bits;
    logic [1:0]  len;
    logic        fin;
  } grp_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [7:0] sextet_to_char(input logic [5:0] v);
    logic [7:0] w;
    w = {2'b00, v};
    if (v < 6'd26) begin
      return 8'h41 + w;
    end else if (v < 6'd52) begin
      return 8'h61 + w - 8'd26;
    end else if (v < 6'd62) begin
      return 8'h30 + w - 8'd52;
    end else if (v == 6'd62) begin
      return 8'h2B;
    end else begin
      return 8'h2F;
    end
  endfunction

endpackage
`default_nettype wire

[rtl/b64e_front.sv]
`default_nettype none
module b64e_front (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  push,
  output logic                 full,
  input  wire  [7:0]           data_byte_i,
  input  wire                  last_byte_i,
  input  b64e_pkg::q_stat_t    q_stat_i,
  output logic                 q_push_o,
  output b64e_pkg::grp_t       q_data_o
);
  import b64e_pkg::*;

  logic [15:0] pend_q, pend_d;
  logic [1:0]  cnt_q, cnt_d;
  logic [1:0]  held;
  logic [1:0]  total;
  logic        accept;
  logic        close;

  assign full   = q_stat_i.full;
  assign accept = push && !q_stat_i.full;
  assign held   = (cnt_q == 2'd3) ? 2'd2 : cnt_q;
  assign total  = held + 2'd1;
  assign close  = (total == LenThree) || last_byte_i;

  always_comb begin
    pend_d        = pend_q;
    cnt_d         = cnt_q;
    q_push_o      = 1'b0;
    q_data_o.len  = total;
    q_data_o.fin  = last_byte_i;
    unique case (total)
      LenThree: q_data_o.bits = {pend_q, data_byte_i};
      LenTwo:   q_data_o.bits = {pend_q[7:0], data_byte_i, 8'h00};
      default:  q_data_o.bits = {data_byte_i, 16'h0000};
    endcase
    if (accept) begin
      if (close) begin
        q_push_o = 1'b1;
        pend_d   = '0;
        cnt_d    = '0;
      end else begin
        pend_d = {pend_q[7:0], data_byte_i};
        cnt_d  = total;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
      cnt_q  <= '0;
    end else begin
      pend_q <= pend_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule
`default_nettype wire

[rtl/b64e_queue.sv]
`default_nettype none
module b64e_queue #(
  parameter int unsigned Depth = b64e_pkg::QueueDepthDef
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  push_i,
  input  b64e_pkg::grp_t       push_data_i,
  input  wire                  pop_i,
  output b64e_pkg::grp_t       pop_data_o,
  output b64e_pkg::q_stat_t    stat_o
);
  import b64e_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  grp_t          mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d;
  logic [PtrW-1:0] rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push;
  logic            do_pop;

  assign stat_o.full  = (cnt_q == FullCnt);
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign pop_data_o   = mem_q[rd_q];

  always_comb begin
    wr_d  = do_push ? ((wr_q == LastPtr) ? '0 : wr_q + 1'b1) : wr_q;
    rd_d  = do_pop ? ((rd_q == LastPtr) ? '0 : rd_q + 1'b1) : rd_q;
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FullCnt)
    else $error("group queue count above depth");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> (cnt_q == $past(cnt_q) + 1'b1))
    else $error("group queue lost a transfer");
`endif

endmodule
`default_nettype wire

[rtl/b64e_back.sv]
`default_nettype none
module b64e_back (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  b64e_pkg::grp_t       grp_i,
  input  b64e_pkg::q_stat_t    q_stat_i,
  output logic                 q_pop_o,
  output logic                 empty,
  input  wire                  pop,
  output logic [7:0]           char_code_o,
  output logic                 last_char_o
);
  import b64e_pkg::*;

  logic [1:0] pos_q, pos_d;
  logic       vld_q, vld_d;
  logic [7:0] char_q, char_d;
  logic       last_q, last_d;
  logic       load;
  logic       pad;
  logic [5:0] sextet;

  assign empty       = !vld_q;
  assign char_code_o = char_q;
  assign last_char_o = last_q;
  assign load        = !q_stat_i.empty && (!vld_q || pop);
  assign q_pop_o     = load && (pos_q == PosFourth);

  always_comb begin
    unique case (pos_q)
      PosFirst:  sextet = grp_i.bits[23:18];
      PosSecond: sextet = grp_i.bits[17:12];
      PosThird:  sextet = grp_i.bits[11:6];
      default:   sextet = grp_i.bits[5:0];
    endcase
    pad = ((pos_q == PosThird) && (grp_i.len == LenOne)) ||
          ((pos_q == PosFourth) && (grp_i.len != LenThree));
    pos_d  = pos_q;
    vld_d  = vld_q;
    char_d = char_q;
    last_d = last_q;
    if (load) begin
      pos_d  = pos_q + 2'd1;
      vld_d  = 1'b1;
      char_d = pad ? PadChar : sextet_to_char(sextet);
      last_d = (pos_q == PosFourth) && grp_i.fin;
    end else if (pop) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= PosFirst;
      vld_q <= 1'b0;
    end else begin
      pos_q <= pos_d;
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    char_q <= char_d;
    last_q <= last_d;
  end

`ifndef SYNTHESIS
  a_group_wraps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && (pos_q == PosFourth)) |=> (pos_q == PosFirst))
    else $error("character position did not wrap after a group");

  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> vld_q)
    else $error("loaded character not presented");

  a_last_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q && last_q) |-> (pos_q == PosFirst))
    else $error("final character marked inside a group");
`endif

endmodule
`default_nettype wire

[rtl/base64_encoder_unit.sv]
// Flow: the edge that accepts the byte closing a group writes the group into the
// group queue; the output register then loads its first character, and the other
// three follow one per cycle while the consumer keeps popping.
// Throughput: one character per cycle while the consumer pops; each group of three
// bytes gives four characters, so the single character register sets the byte rate.
// Reset: asynchronous, active low; clears the held bytes, the group queue and the
// output valid flag (not the character register), so the block starts empty.
`default_nettype none
module base64_encoder_unit #(
  parameter int unsigned QueueDepth = b64e_pkg::QueueDepthDef
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        push,
  output logic       full,
  input  wire  [7:0] data_byte_i,
  input  wire        last_byte_i,
  output logic       empty,
  input  wire        pop,
  output logic [7:0] char_code_o,
  output logic       last_char_o
);
  import b64e_pkg::*;

  grp_t    q_wdata;
  grp_t    q_rdata;
  q_stat_t q_stat;
  logic    q_push;
  logic    q_pop;

  b64e_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .q_stat_i    (q_stat),
    .q_push_o    (q_push),
    .q_data_o    (q_wdata)
  );

  b64e_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_wdata),
    .pop_i       (q_pop),
    .pop_data_o  (q_rdata),
    .stat_o      (q_stat)
  );

  b64e_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .grp_i       (q_rdata),
    .q_stat_i    (q_stat),
    .q_pop_o     (q_pop),
    .empty       (empty),
    .pop         (pop),
    .char_code_o (char_code_o),
    .last_char_o (last_char_o)
  );

endmodule
`default_nettype wire
